### rtl/hpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcf_pkg
// Shared types and fixed constants of the histogram peak centroid finder.
// ----------------------------------------------------------------------------
package hpcf_pkg;

   // Fixed port widths.
   localparam int IN_COUNT_W = 16;
   localparam int CFG_W      = 16;
   localparam int POS_W      = 20;
   localparam int HEIGHT_W   = 16;

   // Saturation value of the centroid and reset value of the threshold.
   localparam logic [POS_W-1:0] POS_MAX          = {POS_W{1'b1}};
   localparam logic [CFG_W-1:0] MIN_HEIGHT_RESET = CFG_W'(1);

   // A peak test needs the left and center bins already in the window.
   localparam logic [1:0] WINDOW_SPAN = 2'd2;

   // Entries in the queue between detection and division; a power of two.
   localparam int QUEUE_DEPTH = 2;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } hpcf_queue_status_type;

   // Back-end sequencer states.
   typedef enum logic [4:0] {
      BK_IDLE = 5'b00001,
      BK_SUM  = 5'b00010,
      BK_MUL  = 5'b00100,
      BK_DIV  = 5'b01000,
      BK_DONE = 5'b10000
   } hpcf_back_state_type;

endpackage

### rtl/histogram_peak_centroid_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_peak_centroid_finder
// Three-bin local-maximum peak finder that reports the count-weighted
// centroid of each peak in fixed point.
// ----------------------------------------------------------------------------
// Bins are taken at one beat per cycle while the two-entry peak queue has
// room; once the queue is full every bin waits, peak or not, until the back
// end takes the oldest peak. The back end handles one peak at a time in
// steps: one to take it from the queue, one for the three-bin sum, one for
// the weighted numerator, one per quotient bit in the restoring divider, and
// one to load the output register. A stalled result holds the back end in
// its last step. Since two neighboring bins cannot both be peaks, bins
// stall only when peaks arrive faster than the back end retires them or the
// result side holds off. The threshold register resets to 1 and takes a
// write on every csr_valid.
// ----------------------------------------------------------------------------
module histogram_peak_centroid_finder #(
   parameter int MAX_BINS      = 4096,
   parameter int COUNT_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hpcf_pkg::IN_COUNT_W-1:0]   req_bin_count,
   input  logic                              req_last_bin,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hpcf_pkg::POS_W-1:0]        rsp_peak_position,
   output logic [hpcf_pkg::HEIGHT_W-1:0]     rsp_peak_height,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hpcf_pkg::CFG_W-1:0]        csr_min_peak_height
);
   import hpcf_pkg::*;

   localparam int ENTRY_W = $clog2(MAX_BINS) + 3 * COUNT_BITS;

   hpcf_queue_status_type q_status;
   logic                  push;
   logic                  pop;
   logic [ENTRY_W-1:0]    push_data;
   logic [ENTRY_W-1:0]    pop_data;

   // Window and detection.
   hpcf_front #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_bin_count       (req_bin_count),
      .req_last_bin        (req_last_bin),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_min_peak_height (csr_min_peak_height),
      .q_status            (q_status),
      .push                (push),
      .push_data           (push_data)
   );

   // Peak queue.
   hpcf_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Centroid divider and result register.
   hpcf_back #(
      .MAX_BINS      (MAX_BINS),
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop               (pop),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_peak_position (rsp_peak_position),
      .rsp_peak_height   (rsp_peak_height)
   );

endmodule

### rtl/hpcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcf_queue
// Short first-in first-out queue that holds detected peaks until the
// divider is free.
// ----------------------------------------------------------------------------
module hpcf_queue #(
   parameter int WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output hpcf_pkg::hpcf_queue_status_type status
);
   import hpcf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Status flags.
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally because the depth is a power of two.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written on each pushed beat.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/hpcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcf_front
// Bin window and peak detection; holds the threshold register and pushes
// each detected peak into the queue.
// ----------------------------------------------------------------------------
module hpcf_front #(
   parameter int MAX_BINS   = 4096,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [hpcf_pkg::IN_COUNT_W-1:0]       req_bin_count,
   input  logic                                  req_last_bin,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hpcf_pkg::CFG_W-1:0]            csr_min_peak_height,
   input  hpcf_pkg::hpcf_queue_status_type       q_status,
   output logic                                  push,
   output logic [$clog2(MAX_BINS)+3*COUNT_BITS-1:0] push_data
);
   import hpcf_pkg::*;

   localparam int BIN_BITS = $clog2(MAX_BINS);
   localparam int HW       = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [COUNT_BITS-1:0] older_ff, older_in;
   logic [COUNT_BITS-1:0] middle_ff, middle_in;
   logic [1:0]            fill_ff, fill_in;
   logic [CFG_W-1:0]      min_height_ff;

   logic                  accept;
   logic                  last;
   logic                  is_peak;
   logic [COUNT_BITS-1:0] count;
   logic [BIN_BITS-1:0]   center;

   // Threshold register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= MIN_HEIGHT_RESET;
      end else if (csr_valid) begin
         min_height_ff <= csr_min_peak_height;
      end
   end

   // A beat waits only while the queue is full.
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign count     = COUNT_BITS'(req_bin_count);
   assign last      = req_last_bin || (bin_ff == BIN_BITS'(MAX_BINS - 1));
   assign center    = bin_ff - BIN_BITS'(1);

   // The middle bin is a peak when it rises from the left, does not fall
   // below the right, and reaches the threshold.
   assign is_peak = (fill_ff == WINDOW_SPAN) && (middle_ff > older_ff) &&
                    (middle_ff >= count) &&
                    (HW'(middle_ff) >= HW'(min_height_ff));

   assign push      = accept && is_peak;
   assign push_data = {center, older_ff, middle_ff, count};

   // Window update; the last bin starts a new histogram.
   always_comb begin
      bin_in    = bin_ff;
      older_in  = older_ff;
      middle_in = middle_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (last) begin
            bin_in    = '0;
            older_in  = '0;
            middle_in = '0;
            fill_in   = '0;
         end else begin
            bin_in    = bin_ff + BIN_BITS'(1);
            older_in  = middle_ff;
            middle_in = count;
            if (fill_ff != WINDOW_SPAN) begin
               fill_in = fill_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff    <= '0;
         older_ff  <= '0;
         middle_ff <= '0;
         fill_ff   <= '0;
      end else begin
         bin_ff    <= bin_in;
         older_ff  <= older_in;
         middle_ff <= middle_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/hpcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcf_back
// Centroid computation: sum, weighted numerator, then a restoring divider
// that retires one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module hpcf_back #(
   parameter int MAX_BINS      = 4096,
   parameter int COUNT_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hpcf_pkg::hpcf_queue_status_type       q_status,
   output logic                                  pop,
   input  logic [$clog2(MAX_BINS)+3*COUNT_BITS-1:0] pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hpcf_pkg::POS_W-1:0]            rsp_peak_position,
   output logic [hpcf_pkg::HEIGHT_W-1:0]         rsp_peak_height
);
   import hpcf_pkg::*;

   localparam int BIN_BITS = $clog2(MAX_BINS);
   localparam int DW       = COUNT_BITS + 2;          // three-bin sum
   localparam int NUMW     = BIN_BITS + DW;           // weighted numerator
   localparam int QW       = BIN_BITS + FRACTION_BITS; // quotient bits
   localparam int STEP_W   = $clog2(QW);
   localparam int CMPW     = (QW > POS_W) ? QW : POS_W;

   hpcf_back_state_type    state_ff, state_in;
   logic [BIN_BITS-1:0]    center_ff, center_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic [COUNT_BITS-1:0]  mid_ff, mid_in;
   logic [COUNT_BITS-1:0]  right_ff, right_in;
   logic [DW-1:0]          sum_ff, sum_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [QW-1:0]          quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]       position_ff, position_in;
   logic [HEIGHT_W-1:0]    height_ff, height_in;

   logic [NUMW-1:0]        num;
   logic [DW:0]            trial;
   logic                   fits;
   logic [POS_W-1:0]       position;
   logic                   out_free;

   // Weighted numerator; never negative because the center bin is at least 1.
   assign num = NUMW'(center_ff) * NUMW'(sum_ff) + NUMW'(right_ff) - NUMW'(left_ff);

   // One divider step: bring down the next dividend bit and try the sum.
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits  = (trial >= {1'b0, sum_ff});

   // Saturate the quotient at the output width.
   assign position = (CMPW'(quo_ff) > CMPW'(POS_MAX)) ? POS_MAX : POS_W'(quo_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      center_in    = center_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      right_in     = right_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      position_in  = position_ff;
      height_in    = height_ff;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               {center_in, left_in, mid_in, right_in} = pop_data;
               state_in = BK_SUM;
            end
         end
         BK_SUM: begin
            sum_in   = DW'(left_ff) + DW'(mid_ff) + DW'(right_ff);
            state_in = BK_MUL;
         end
         BK_MUL: begin
            // Load the dividend: the upper bits, already below the sum, go
            // to the remainder, the low bits and the fraction zeros to the
            // quotient register.
            rem_in   = DW'(num >> BIN_BITS);
            quo_in   = QW'(num[BIN_BITS-1:0]) << FRACTION_BITS;
            state_in = BK_DIV;
            step_in  = '0;
         end
         BK_DIV: begin
            // One quotient bit per step.
            if (fits) begin
               rem_in = DW'(trial - {1'b0, sum_ff});
            end else begin
               rem_in = trial[DW-1:0];
            end
            quo_in  = {quo_ff[QW-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QW - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               position_in  = position;
               height_in    = HEIGHT_W'(mid_ff);
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff   <= center_in;
      left_ff     <= left_in;
      mid_ff      <= mid_in;
      right_ff    <= right_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      position_ff <= position_in;
      height_ff   <= height_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_peak_position = position_ff;
   assign rsp_peak_height   = height_ff;

   // The partial remainder always stays below the divisor.
   a_rem_below_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (rem_ff < sum_ff))
      else $error("divider remainder not below the sum");

   // A peak always has a nonzero three-bin sum.
   a_sum_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (sum_ff != '0))
      else $error("zero divisor in the divider");

   // The step counter never runs past the quotient width.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (step_ff <= STEP_W'(QW - 1)))
      else $error("divider step count out of range");

   // A new result beat appears only out of the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_DONE))
      else $error("result raised outside the done state");

endmodule

### dv/hpcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcf_checker
// Watches the bin, peak and threshold channels of the peak centroid finder,
// predicts every peak from the accepted bins and compares each peak beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hpcf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [hpcf_pkg::IN_COUNT_W-1:0]   req_bin_count,
   input  logic                              req_last_bin,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [hpcf_pkg::POS_W-1:0]        rsp_peak_position,
   input  logic [hpcf_pkg::HEIGHT_W-1:0]     rsp_peak_height,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [hpcf_pkg::CFG_W-1:0]        csr_min_peak_height,
   output int unsigned                       peaks_outstanding,
   output int unsigned                       mismatch_count
);

   import hpcf_pkg::*;

   // The block is instantiated with its default parameters.
   localparam int MAX_BINS      = 4096;
   localparam int FRACTION_BITS = 8;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [HEIGHT_W-1:0] height;
   } peak_rec_type;

   // Peaks predicted but not yet seen on the result channel, oldest first.
   peak_rec_type expected_peaks[$];

   // Window state of the prediction.
   logic [11:0]         bin_index;
   logic [15:0]         left_count;
   logic [15:0]         center_count;
   logic [1:0]          window_fill;
   logic [CFG_W-1:0]    height_floor;

   // Count-weighted centroid of three bins, in fixed point, truncated and saturated.
   // The sum is never zero here: a peak's center exceeds its left bin.
   function automatic logic [POS_W-1:0] weighted_center(
      input longint unsigned center_bin,
      input longint unsigned left,
      input longint unsigned mid,
      input longint unsigned right
   );
      longint unsigned total;
      longint unsigned numer;
      longint unsigned quot;
      total = left + mid + right;
      numer = center_bin * total + right - left;
      quot  = (numer << FRACTION_BITS) / total;
      if (quot > POS_MAX) begin
         quot = POS_MAX;
      end
      return quot[POS_W-1:0];
   endfunction

   // Shift one bin into the window and queue a peak when the middle bin
   // qualifies. A histogram closes on its mark or on the highest index.
   function automatic void advance_window(input logic [15:0] count, input logic mark);
      logic         closing;
      peak_rec_type peak;
      closing = mark || (bin_index >= MAX_BINS - 1);
      if (window_fill >= WINDOW_SPAN && bin_index >= 2) begin
         if (center_count > left_count && center_count >= count &&
             center_count >= height_floor) begin
            peak.position = weighted_center(bin_index - 1, left_count, center_count, count);
            peak.height   = center_count;
            expected_peaks = {expected_peaks, peak};
         end
      end
      left_count   = center_count;
      center_count = count;
      if (window_fill < WINDOW_SPAN) begin
         window_fill = window_fill + 1'b1;
      end
      if (closing) begin
         bin_index    = '0;
         left_count   = '0;
         center_count = '0;
         window_fill  = '0;
      end else begin
         bin_index = bin_index + 1'b1;
      end
   endfunction

   // Results are compared before new bins are absorbed: no peak can leave
   // the block in the cycle its right neighbor arrives.
   always @(posedge clock) begin
      peak_rec_type want;
      if (reset) begin
         expected_peaks.delete();
         bin_index      = '0;
         left_count     = '0;
         center_count   = '0;
         window_fill    = '0;
         height_floor   = MIN_HEIGHT_RESET;
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            height_floor = csr_min_peak_height;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_peaks.size() == 0) begin
               $error("unexpected peak beat: peak_position %0d, peak_height %0d",
                      rsp_peak_position, rsp_peak_height);
               mismatch_count++;
            end else begin
               want = expected_peaks[0];
               expected_peaks.delete(0);
               if (rsp_peak_position !== want.position) begin
                  $error("peak_position: expected %0d, actual %0d",
                         want.position, rsp_peak_position);
                  mismatch_count++;
               end
               if (rsp_peak_height !== want.height) begin
                  $error("peak_height: expected %0d, actual %0d",
                         want.height, rsp_peak_height);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_window(req_bin_count, req_last_bin);
         end
      end
      peaks_outstanding <= expected_peaks.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the histogram peak centroid finder.
// ----------------------------------------------------------------------------
// Streams histograms of bin counts into the block, first a directed set of
// edge cases, then random histograms in phases with different thresholds,
// random sender and receiver idling and a long receiver hold-off. The
// checker predicts and compares every peak beat.
// ----------------------------------------------------------------------------
module testbench;

   import hpcf_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 32;
   localparam int LONG_HOLD       = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int PRESSURE_PHASE  = 3;
   localparam int QUIET_PHASE     = 5;

   // How the counts of one random histogram are drawn.
   typedef enum logic [1:0] {
      SHAPE_FULL,
      SHAPE_TINY,
      SHAPE_TOP,
      SHAPE_ZIGZAG
   } count_shape_type;

   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic [IN_COUNT_W-1:0] req_bin_count       = '0;
   logic                  req_last_bin        = 1'b0;
   logic                  rsp_stall           = 1'b0;
   logic                  csr_valid           = 1'b0;
   logic [CFG_W-1:0]      csr_min_peak_height = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [POS_W-1:0]      rsp_peak_position;
   logic [HEIGHT_W-1:0]   rsp_peak_height;
   logic                  csr_ready;

   int unsigned           peaks_outstanding;
   int unsigned           mismatch_count;
   int unsigned           quiet_cycles        = 0;
   logic                  req_gaps            = 1'b1;
   logic                  rsp_gaps            = 1'b1;
   logic                  long_hold_pending   = 1'b0;

   histogram_peak_centroid_finder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_bin_count       (req_bin_count),
      .req_last_bin        (req_last_bin),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_peak_position   (rsp_peak_position),
      .rsp_peak_height     (rsp_peak_height),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_min_peak_height (csr_min_peak_height)
   );

   hpcf_checker peak_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_bin_count       (req_bin_count),
      .req_last_bin        (req_last_bin),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_peak_position   (rsp_peak_position),
      .rsp_peak_height     (rsp_peak_height),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_min_peak_height (csr_min_peak_height),
      .peaks_outstanding   (peaks_outstanding),
      .mismatch_count      (mismatch_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // The run ends when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : peak_receiver
      logic hold_served;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall   <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one bin beat, after an optional idle burst, and wait for it to
   // be taken. Called right after a rising edge.
   task automatic put_bin(input logic [IN_COUNT_W-1:0] count, input logic mark);
      if (req_gaps && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bin_count <= count;
      req_last_bin  <= mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [IN_COUNT_W-1:0] draw_count(
      input count_shape_type shape,
      input int unsigned     pos
   );
      case (shape)
         SHAPE_TINY:   return IN_COUNT_W'($urandom_range(0, 4));
         SHAPE_TOP:    return IN_COUNT_W'(16'hFFFF - $urandom_range(0, 3));
         SHAPE_ZIGZAG: return pos[0] ? IN_COUNT_W'($urandom_range(256, 65535))
                                     : IN_COUNT_W'($urandom_range(0, 255));
         default:      return IN_COUNT_W'($urandom);
      endcase
   endfunction

   // One histogram, marked on its final bin.
   task automatic send_histogram(input int unsigned nbins, input count_shape_type shape);
      for (int unsigned i = 0; i < nbins; i++) begin
         put_bin(draw_count(shape, i), i == nbins - 1);
      end
   endtask

   // Wait until every predicted peak has come out and the back end is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (peaks_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [CFG_W-1:0] level);
      csr_valid           <= 1'b1;
      csr_min_peak_height <= level;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : bin_source
      int unsigned      phase;
      int unsigned      phase_items;
      int unsigned      nbins;
      logic             gaps_now;
      logic [CFG_W-1:0] level;
      count_shape_type  shape;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Threshold at its reset value. Equal full-scale neighbors: the
      // earlier one is the peak.
      put_bin(16'd0, 1'b0);
      put_bin(16'hFFFF, 1'b0);
      put_bin(16'hFFFF, 1'b0);
      put_bin(16'd7, 1'b1);
      // Two-bin and one-bin histograms give nothing.
      put_bin(16'd5, 1'b0);
      put_bin(16'd3, 1'b1);
      put_bin(16'd9, 1'b1);
      // Rising start: bin zero is never a peak.
      put_bin(16'd1, 1'b0);
      put_bin(16'd2, 1'b0);
      put_bin(16'd3, 1'b0);
      put_bin(16'd1, 1'b1);
      // Center equal to the threshold; a rising final bin is never a peak.
      put_bin(16'd0, 1'b0);
      put_bin(16'd1, 1'b0);
      put_bin(16'd0, 1'b0);
      put_bin(16'd2, 1'b0);
      put_bin(16'd3, 1'b1);

      // A zero threshold behaves like a threshold of one.
      drain();
      write_threshold('0);
      put_bin(16'd0, 1'b0);
      put_bin(16'd1, 1'b0);
      put_bin(16'd0, 1'b1);

      // Full-scale threshold: only a full-scale center passes.
      drain();
      write_threshold('1);
      put_bin(16'd0, 1'b0);
      put_bin(16'hFFFF, 1'b0);
      put_bin(16'hFFFF, 1'b1);
      put_bin(16'd3, 1'b0);
      put_bin(16'hFFFE, 1'b0);
      put_bin(16'd0, 1'b1);

      // Random histograms, one threshold per phase.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         case (phase)
            0:              level = '0;
            1:              level = '1;
            PRESSURE_PHASE: level = MIN_HEIGHT_RESET;
            4:              level = CFG_W'($urandom_range(0, 8));
            6:              level = CFG_W'(2);
            7:              level = MIN_HEIGHT_RESET;
            default:        level = CFG_W'($urandom_range(0, 65535));
         endcase
         write_threshold(level);
         gaps_now = (phase != 2 && phase != QUIET_PHASE && phase != NUM_PHASES - 1);
         req_gaps = gaps_now;
         rsp_gaps <= gaps_now;

         if (phase == PRESSURE_PHASE) begin
            // The receiver holds off while dense peaks keep arriving, so the
            // peak queue fills and the block stalls its bin input.
            req_gaps = 1'b0;
            long_hold_pending <= 1'b1;
            send_histogram(120, SHAPE_ZIGZAG);
            req_gaps = gaps_now;
         end

         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            nbins = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                : $urandom_range(3, 40);
            shape = count_shape_type'($urandom_range(0, 3));
            send_histogram(nbins, shape);
            phase_items += nbins;
         end
      end

      drain();
      if (mismatch_count == 0 && peaks_outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
